>>> hw/rtl/stable_priority_queue_with_credit_defines.svh
// ============================================================================
// Assertion macros for the credit priority queue
// Shared same-cycle and next-cycle implication checks used by the RTL.
// ============================================================================
`ifndef STABLE_PRIORITY_QUEUE_WITH_CREDIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_WITH_CREDIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed: same-cycle implication");

// next-cycle implication
`define SPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed: next-cycle implication");

`else

`define SPQ_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/spqc_pkg.sv
// ============================================================================
// spqc_pkg
// Widths, codes and controller/datapath command types of the credit queue.
// ============================================================================
package spqc_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 2;
    localparam int STK_W    = 16;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = ID_W + PRIO_W;

    localparam logic [STK_W-1:0] STOCK_MAX = {STK_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_SERVE   = 2'd1,
        OP_RETURN  = 2'd2,
        OP_CANCEL  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_NO_STOCK  = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4
    } t_status;

    // one queue slot
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // walk index update
    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_ZERO = 3'd1,
        IDX_TAIL = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        WA_ZERO = 2'd0,
        WA_NEXT = 2'd1,
        WA_PREV = 2'd2
    } t_waddr_sel;

    typedef enum logic {
        WD_KEY   = 1'b0,
        WD_RDATA = 1'b1
    } t_wdata_sel;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_INC  = 2'd1,
        STK_DEC  = 2'd2
    } t_stk_op;

    // controller -> datapath
    typedef struct packed {
        logic       load_key;
        t_idx_op    idx_op;
        logic       wr_en;
        t_waddr_sel waddr_sel;
        t_wdata_sel wdata_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        t_stk_op    stk_op;
        logic       set_status;
        t_status    status_val;
        logic       capture;
        logic       publish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic stock_zero;
        logic rd_prio_gt;
        logic rd_id_eq;
        logic idx_zero;
        logic idx_tail;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/spqc_ram.sv
// ============================================================================
// spqc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module spqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/spqc_ctrl.sv
// ============================================================================
// spqc_ctrl
// Sequencer for the credit queue: decodes an operation and walks the slots.
// ============================================================================
module spqc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [spqc_pkg::OP_W-1:0]     i_operation,
    input  spqc_pkg::t_dp_sts             i_sts,
    output spqc_pkg::t_dp_cmd             o_cmd
);

    import spqc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ENQ_WALK = 7'b0000010,
        ST_ENQ_HEAD = 7'b0000100,
        ST_SRV_HEAD = 7'b0001000,
        ST_CAN_SCAN = 7'b0010000,
        ST_SHIFT    = 7'b0100000,
        ST_PUB      = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_key = 1'b1;
                    case (t_op'(i_operation))
                        OP_ENQUEUE: begin
                            if (i_sts.count_full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status_val = STS_FULL;
                                n_state          = ST_PUB;
                            end else if (i_sts.count_zero) begin
                                o_cmd.wr_en     = 1'b1;
                                o_cmd.waddr_sel = WA_ZERO;
                                o_cmd.wdata_sel = WD_KEY;
                                o_cmd.cnt_inc   = 1'b1;
                                n_state         = ST_PUB;
                            end else begin
                                o_cmd.idx_op = IDX_TAIL;
                                n_state      = ST_ENQ_WALK;
                            end
                        end
                        OP_SERVE: begin
                            if (i_sts.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status_val = STS_EMPTY;
                                n_state          = ST_PUB;
                            end else if (i_sts.stock_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status_val = STS_NO_STOCK;
                                n_state          = ST_PUB;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                                n_state      = ST_SRV_HEAD;
                            end
                        end
                        OP_RETURN: begin
                            o_cmd.stk_op = STK_INC;
                            n_state      = ST_PUB;
                        end
                        OP_CANCEL: begin
                            if (i_sts.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status_val = STS_EMPTY;
                                n_state          = ST_PUB;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                                n_state      = ST_CAN_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_PUB;
                        end
                    endcase
                end
            end
            // walk from the tail, moving lower-priority slots up by one
            ST_ENQ_WALK: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.waddr_sel = WA_NEXT;
                if (i_sts.rd_prio_gt) begin
                    o_cmd.wdata_sel = WD_RDATA;
                    if (i_sts.idx_zero) begin
                        n_state = ST_ENQ_HEAD;
                    end else begin
                        o_cmd.idx_op = IDX_DEC;
                    end
                end else begin
                    o_cmd.wdata_sel = WD_KEY;
                    o_cmd.cnt_inc   = 1'b1;
                    n_state         = ST_PUB;
                end
            end
            // every slot moved: new entry becomes the head
            ST_ENQ_HEAD: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.waddr_sel = WA_ZERO;
                o_cmd.wdata_sel = WD_KEY;
                o_cmd.cnt_inc   = 1'b1;
                n_state         = ST_PUB;
            end
            ST_SRV_HEAD: begin
                o_cmd.capture = 1'b1;
                o_cmd.stk_op  = STK_DEC;
                if (i_sts.idx_tail) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = ST_PUB;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = ST_SHIFT;
                end
            end
            // scan from the head for the first matching id
            ST_CAN_SCAN: begin
                if (i_sts.rd_id_eq) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.idx_tail) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = ST_PUB;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                        n_state      = ST_SHIFT;
                    end
                end else if (i_sts.idx_tail) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = STS_NOT_FOUND;
                    n_state          = ST_PUB;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            // close the gap: each slot moves down by one
            ST_SHIFT: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.waddr_sel = WA_PREV;
                o_cmd.wdata_sel = WD_RDATA;
                if (i_sts.idx_tail) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = ST_PUB;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            // hand the result to the output register once it is free
            ST_PUB: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/spqc_dp.sv
// ============================================================================
// spqc_dp
// Datapath of the credit queue: slot RAM, walk index, counters, result regs.
// ============================================================================
`include "stable_priority_queue_with_credit_defines.svh"

module spqc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spqc_pkg::STK_W-1:0]      i_cfg_data,
    input  logic [spqc_pkg::ID_W-1:0]       i_borrower_id,
    input  logic [spqc_pkg::PRIO_W-1:0]     i_priority_req,
    input  spqc_pkg::t_dp_cmd               i_cmd,
    output spqc_pkg::t_dp_sts               o_sts,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [spqc_pkg::STATUS_W-1:0]   o_status,
    output logic [spqc_pkg::ID_W-1:0]       o_served_id,
    output logic [spqc_pkg::PRIO_W-1:0]     o_served_priority,
    output logic [spqc_pkg::CNT_W-1:0]      o_queue_count,
    output logic [spqc_pkg::STK_W-1:0]      o_stock_level
);

    import spqc_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [STK_W-1:0]  r_stock;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_valid;
    logic [ID_W-1:0]   r_key_id;
    logic [PRIO_W-1:0] r_key_prio;
    t_status           r_status;
    logic [ID_W-1:0]   r_got_id;
    logic [PRIO_W-1:0] r_got_prio;

    logic [ID_W-1:0]    key_id;
    logic [PRIO_W-1:0]  key_prio, in_prio;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata, rd_word;
    t_entry             rd_entry, key_entry;

    // priority zero counts as the highest priority
    assign in_prio  = (i_priority_req == '0) ? PRIO_W'(1) : i_priority_req;
    assign key_id   = i_cmd.load_key ? i_borrower_id : r_key_id;
    assign key_prio = i_cmd.load_key ? in_prio : r_key_prio;
    assign key_entry = '{id: key_id, prio: key_prio};
    assign rd_entry  = t_entry'(rd_word);

    // walk index; the RAM reads the next index so read data tracks r_idx
    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO: n_idx = '0;
            IDX_TAIL: n_idx = IDX_W'(r_count - CNT_W'(1));
            IDX_INC:  n_idx = r_idx + IDX_W'(1);
            IDX_DEC:  n_idx = r_idx - IDX_W'(1);
            default:  n_idx = r_idx;
        endcase
    end

    // write address and data
    always_comb begin
        case (i_cmd.waddr_sel)
            WA_NEXT: waddr = r_idx + IDX_W'(1);
            WA_PREV: waddr = r_idx - IDX_W'(1);
            default: waddr = '0;
        endcase
    end

    assign wdata = (i_cmd.wdata_sel == WD_RDATA) ? rd_word : ENTRY_W'(key_entry);

    spqc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_idx),
        .o_rdata (rd_word)
    );

    // status toward the controller
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.stock_zero = (r_stock == '0);
    assign o_sts.rd_prio_gt = (rd_entry.prio > r_key_prio);
    assign o_sts.rd_id_eq   = (rd_entry.id == r_key_id);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.idx_tail   = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign o_sts.out_free   = !r_valid || !i_stall;

    // control state: counters, index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_stock <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_stock <= i_cfg_data;
            end else begin
                case (i_cmd.stk_op)
                    STK_INC: begin
                        if (r_stock != STOCK_MAX) begin
                            r_stock <= r_stock + STK_W'(1);
                        end
                    end
                    STK_DEC: r_stock <= r_stock - STK_W'(1);
                    default: r_stock <= r_stock;
                endcase
            end
            if (i_cmd.publish) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload: search key, pending result, output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key_id   <= i_borrower_id;
            r_key_prio <= in_prio;
            r_status   <= STS_OK;
            r_got_id   <= '0;
            r_got_prio <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_val;
        end
        if (i_cmd.capture) begin
            r_got_id   <= rd_entry.id;
            r_got_prio <= rd_entry.prio;
        end
        if (i_cmd.publish) begin
            o_status          <= r_status;
            o_served_id       <= r_got_id;
            o_served_priority <= r_got_prio;
            o_queue_count     <= r_count;
            o_stock_level     <= r_stock;
        end
    end

    assign o_valid = r_valid;

    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_IMP(a_pub_free, i_clk, i_rst_n, i_cmd.publish, o_sts.out_free)
    `SPQ_ASSERT_IMP(a_wr_range, i_clk, i_rst_n, i_cmd.wr_en, CNT_W'(waddr) <= r_count)
    `SPQ_ASSERT_NXT(a_got_prio, i_clk, i_rst_n, i_cmd.capture, r_got_prio != '0)

endmodule

>>> hw/rtl/stable_priority_queue_with_credit.sv
// ============================================================================
// stable_priority_queue_with_credit
// Bounded priority queue of requester ids with a credit stock counter.
// ============================================================================
// Usage:
//   Request channel: i_valid / o_stall with i_operation, i_borrower_id and
//   i_priority_req; a transfer happens when i_valid is high and o_stall low.
//   Result channel: o_valid / i_stall with o_status, o_served_id,
//   o_served_priority, o_queue_count and o_stock_level; one result per request.
//   i_cfg_we with i_cfg_data loads the stock counter; write it while idle.
//   Flow: return, rejected requests and enqueue into an empty queue go from
//   the idle decode straight to the publish state. Serve and cancel walk the
//   slots first, and enqueue walks from the tail (then writes the head when the
//   new entry becomes the head); the walk reads one slot per cycle, at most 16
//   slots (15 for enqueue). One request is in work at a time; the next one is
//   taken right after the result is moved to the output register.
//   A held result does not block the next transfer; only the hand-off of the
//   following result waits while i_stall keeps the output register full.
//   Reset (synchronous, i_rst_n low) empties the queue, clears the stock and
//   drops o_valid; slot contents are not cleared and need no sweep.
// ============================================================================
module stable_priority_queue_with_credit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spqc_pkg::STK_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [spqc_pkg::OP_W-1:0]       i_operation,
    input  logic [spqc_pkg::ID_W-1:0]       i_borrower_id,
    input  logic [spqc_pkg::PRIO_W-1:0]     i_priority_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [spqc_pkg::STATUS_W-1:0]   o_status,
    output logic [spqc_pkg::ID_W-1:0]       o_served_id,
    output logic [spqc_pkg::PRIO_W-1:0]     o_served_priority,
    output logic [spqc_pkg::CNT_W-1:0]      o_queue_count,
    output logic [spqc_pkg::STK_W-1:0]      o_stock_level
);

    import spqc_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    spqc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // storage and arithmetic
    spqc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_borrower_id     (i_borrower_id),
        .i_priority_req    (i_priority_req),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_served_id       (o_served_id),
        .o_served_priority (o_served_priority),
        .o_queue_count     (o_queue_count),
        .o_stock_level     (o_stock_level)
    );

endmodule
